@@ design/bnms_pkg.sv @@
package bnms_pkg;

    // Threshold register, unsigned Q0.16. Values above 0.99 turn suppression off.
    localparam int unsigned THR_W = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd32768;
    localparam logic [THR_W-1:0] THR_OFF_ABOVE = 16'd64880;

    // Limit register.
    localparam int unsigned MAXB_W = 11;
    localparam logic [MAXB_W-1:0] MAXB_RESET = 11'd1024;

    // Kept counter, saturating.
    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Configuration port.
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BOXES = 1'd1;

    // Result word: keep in bit 0, kept_total in bits 16:1, padded to three bytes.
    localparam int unsigned OUT_DW = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic last_issue;
        logic hit;
        logic pipe_empty;
        logic out_free;
    } status_t;

endpackage

@@ design/bnms_ctrl.sv @@
module bnms_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bnms_pkg::status_t status,
    output bnms_pkg::cmd_t    cmd,
    output logic              in_ready
);

    bnms_pkg::state_t state_reg;
    bnms_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bnms_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            bnms_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bnms_pkg::ST_SCAN;
                end
            end
            bnms_pkg::ST_SCAN:
            begin
                // An overlap already found ends the scan early.
                if (!status.need_scan || status.hit)
                begin
                    state_next = bnms_pkg::ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    if (status.last_issue)
                    begin
                        state_next = bnms_pkg::ST_DRAIN;
                    end
                end
            end
            bnms_pkg::ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = bnms_pkg::ST_FINISH;
                end
            end
            bnms_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = bnms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bnms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/bnms_datapath.sv @@
module bnms_datapath
#(
    parameter int unsigned MAX_KEPT   = 1024,
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned S_DW       = 48
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bnms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bnms_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [S_DW-1:0]                     in_data,
    input  logic                                in_last,
    input  bnms_pkg::cmd_t                      cmd,
    output bnms_pkg::status_t                   status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [bnms_pkg::OUT_DW-1:0]         out_data
);

    localparam int unsigned AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int unsigned CW   = $clog2(MAX_KEPT + 1);
    localparam int unsigned CB   = COORD_BITS;
    localparam int unsigned BW   = 4 * CB;
    localparam int unsigned EW   = CB + 1;
    localparam int unsigned AR_W = 2 * CB;
    localparam int unsigned UW   = AR_W + 1;
    localparam int unsigned PW   = UW + bnms_pkg::THR_W;
    localparam int unsigned XW   = bnms_pkg::CNT_W + 1;
    localparam logic [XW-1:0] MAX_KEPT_X = XW'(MAX_KEPT);
    localparam int unsigned PAD_W = bnms_pkg::OUT_DW - bnms_pkg::CNT_W - 1;

    // Overlap of two intervals [a0, a0+al) and [b0, b0+bl).
    function automatic logic [CB-1:0] span_f
    (
        input logic [CB-1:0] a0,
        input logic [CB-1:0] al,
        input logic [CB-1:0] b0,
        input logic [CB-1:0] bl
    );
        logic [EW-1:0] a1;
        logic [EW-1:0] b1;
        logic [EW-1:0] lo;
        logic [EW-1:0] hi;
        logic [EW-1:0] diff;
        begin
            a1   = EW'(a0) + EW'(al);
            b1   = EW'(b0) + EW'(bl);
            lo   = (a0 > b0) ? EW'(a0) : EW'(b0);
            hi   = (a1 < b1) ? a1 : b1;
            diff = hi - lo;
            span_f = (hi > lo) ? diff[CB-1:0] : '0;
        end
    endfunction

    // Configuration registers.
    logic [bnms_pkg::THR_W-1:0]  thr_reg;
    logic [bnms_pkg::MAXB_W-1:0] maxb_reg;

    // Current box and its flags.
    logic [BW-1:0]   cur_reg;
    logic            last_reg;
    logic            off_reg;
    logic            degen_reg;
    logic [AR_W-1:0] area_a_reg;

    logic [bnms_pkg::CNT_W-1:0] kept_count_reg;
    logic [CW-1:0]              issue_cnt_reg;
    logic                       hit_reg;

    // Table of kept boxes; contents are only read below the fill count.
    logic [BW-1:0] mem [MAX_KEPT];
    logic [BW-1:0] rd_data_reg;

    // Comparison pipeline.
    logic [4:0]      vld_reg;
    logic [CB-1:0]   sx_reg;
    logic [CB-1:0]   sy_reg;
    logic [CB-1:0]   bw_reg;
    logic [CB-1:0]   bh_reg;
    logic [AR_W-1:0] inter2_reg;
    logic [AR_W-1:0] area_b_reg;
    logic [AR_W-1:0] inter3_reg;
    logic [UW-1:0]   uni_reg;
    logic [PW-1:0]   prod_reg;
    logic [PW-1:0]   lhs_reg;

    logic [bnms_pkg::OUT_DW-1:0] out_data_reg;
    logic                        out_valid_reg;

    logic [CB-1:0]  in_wid;
    logic [CB-1:0]  in_hgt;
    logic [CB-1:0]  cur_col;
    logic [CB-1:0]  cur_row;
    logic [CB-1:0]  cur_wid;
    logic [CB-1:0]  cur_hgt;
    logic [CB-1:0]  kb_col;
    logic [CB-1:0]  kb_row;
    logic [CB-1:0]  kb_wid;
    logic [CB-1:0]  kb_hgt;
    logic [XW-1:0]  count_x;
    logic           full_c;
    logic           limit_c;
    logic [CW-1:0]  stored_c;
    logic           keep_c;
    logic [bnms_pkg::CNT_W-1:0] total_c;
    logic           mem_we;
    logic [PW-1:0]  prod_c;

    assign in_wid = in_data[3*CB-1:2*CB];
    assign in_hgt = in_data[4*CB-1:3*CB];

    assign cur_col = cur_reg[CB-1:0];
    assign cur_row = cur_reg[2*CB-1:CB];
    assign cur_wid = cur_reg[3*CB-1:2*CB];
    assign cur_hgt = cur_reg[4*CB-1:3*CB];

    assign kb_col = rd_data_reg[CB-1:0];
    assign kb_row = rd_data_reg[2*CB-1:CB];
    assign kb_wid = rd_data_reg[3*CB-1:2*CB];
    assign kb_hgt = rd_data_reg[4*CB-1:3*CB];

    // The count stays put from load to commit, so these are stable during a scan.
    assign count_x  = {1'b0, kept_count_reg};
    assign full_c   = (count_x >= MAX_KEPT_X);
    assign limit_c  = full_c || (count_x >= XW'(maxb_reg));
    assign stored_c = full_c ? CW'(MAX_KEPT) : CW'(kept_count_reg);

    assign keep_c  = off_reg || (!limit_c && !hit_reg);
    assign total_c = (keep_c && (kept_count_reg != bnms_pkg::COUNT_MAX)) ?
                     kept_count_reg + 1'b1 : kept_count_reg;
    assign mem_we  = cmd.commit && keep_c && !full_c;

    assign prod_c = thr_reg * uni_reg;

    assign status.need_scan  = !off_reg && !degen_reg && !limit_c && (stored_c != '0);
    assign status.last_issue = (CW'(issue_cnt_reg + 1'b1) == stored_c);
    assign status.hit        = hit_reg;
    assign status.pipe_empty = (vld_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= bnms_pkg::THR_RESET;
            maxb_reg <= bnms_pkg::MAXB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bnms_pkg::REG_OVERLAP_THRESHOLD:
                begin
                    thr_reg <= cfg_data;
                end
                bnms_pkg::REG_MAX_BOXES:
                begin
                    maxb_reg <= cfg_data[bnms_pkg::MAXB_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count_reg <= '0;
            issue_cnt_reg  <= '0;
            hit_reg        <= 1'b0;
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], cmd.issue};
            if (cmd.load)
            begin
                issue_cnt_reg <= '0;
                hit_reg       <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (vld_reg[4] && (lhs_reg > prod_reg))
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                kept_count_reg <= last_reg ? '0 : total_c;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg    <= in_data[BW-1:0];
            last_reg   <= in_last;
            off_reg    <= (thr_reg > bnms_pkg::THR_OFF_ABOVE);
            degen_reg  <= (in_wid == '0) || (in_hgt == '0);
            area_a_reg <= in_wid * in_hgt;
        end
        if (cmd.commit)
        begin
            out_data_reg <= {PAD_W'(0), total_c, keep_c};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[kept_count_reg[AW-1:0]] <= cur_reg;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[issue_cnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        // Overlap spans along each axis.
        sx_reg <= span_f(cur_col, cur_wid, kb_col, kb_wid);
        sy_reg <= span_f(cur_row, cur_hgt, kb_row, kb_hgt);
        bw_reg <= kb_wid;
        bh_reg <= kb_hgt;
        // Intersection and the kept box's area.
        inter2_reg <= sx_reg * sy_reg;
        area_b_reg <= bw_reg * bh_reg;
        // Union.
        inter3_reg <= inter2_reg;
        uni_reg    <= UW'(area_a_reg) + UW'(area_b_reg) - UW'(inter2_reg);
        // Both sides of inter / union > thr / 65536, cross-multiplied.
        prod_reg <= prod_c;
        lhs_reg  <= PW'({inter3_reg, {bnms_pkg::THR_W{1'b0}}});
    end

endmodule

@@ design/box_non_maximum_suppression_unit.sv @@
// Greedy non-maximum suppression over a stream of candidate boxes that arrive
// already sorted by descending score. Each box transfer is compared against
// every box kept so far in the current set, one intersection-over-union test
// per clock through a five-stage pipeline fed from the kept-box memory, and
// one result transfer (keep flag and running kept total) follows each box.
// The scan reads the boxes kept so far in the set (at most MAX_KEPT) and
// stops early at the first overlap; a box with zero width or height, a box
// past the limit, or any box while suppression is off skips the scan. The
// box with tlast set ends the set and resets the kept count, which empties
// the table. One box is processed at a time; the result register lets the
// next box be taken while a result still waits downstream.
// The kept-box memory has no reset and needs no clearing pass: only entries
// written in the current set are ever read.
module box_non_maximum_suppression_unit
#(
    parameter int unsigned MAX_KEPT   = 1024,
    parameter int unsigned COORD_BITS = 12
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration: index 0 overlap_threshold (Q0.16), index 1 max_boxes.
    input  logic                            cfg_we,
    input  logic [bnms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bnms_pkg::CFG_DATA_W-1:0] cfg_data,

    // Candidate boxes.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // box_col, box_row, box_width, box_height from the lowest bit up, COORD_BITS each
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // last_box
    input  logic                            s_tlast,

    // Results.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // keep (bit 0), kept_total (bits 16:1)
    output logic [bnms_pkg::OUT_DW-1:0]     m_tdata
);

    localparam int unsigned S_DW = ((4 * COORD_BITS + 7) / 8) * 8;

    bnms_pkg::cmd_t    cmd;
    bnms_pkg::status_t status;

    // The sequencer walks each box through load, scan, drain and commit.
    bnms_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    // The datapath holds the configuration, the kept-box table, the comparison
    // pipeline and the result register.
    bnms_datapath
    #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS),
        .S_DW       (S_DW)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

@@ design/bnms_checker.sv @@
module bnms_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bnms_pkg::OUT_DW-1:0] m_tdata
);

    // A result waiting downstream is not withdrawn.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn before its transfer");

    // Boxes are processed one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new box taken while one is in work");

    // A fresh result is only produced while no box is being taken.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a box in work");

    // A kept box is always counted.
    a_kept_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[16:1] != 16'd0))
        else $error("kept box reported with a zero total");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind box_non_maximum_suppression_unit bnms_checker u_bnms_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
